[hw/rtl/hsd_pkg.sv]
// Shared types, type codes and constants of the Hessian 2 scalar decoder.
// Used by hsd_code_decode, hsd_assemble and hessian_scalar_decoder.
`timescale 1ns / 1ps
`default_nettype none

package hsd_pkg;

   // Kind of value the caller expects on a type-code byte
   typedef enum logic [2:0] {
      KIND_INT  = 3'd0,
      KIND_LONG = 3'd1,
      KIND_BOOL = 3'd2,
      KIND_NULL = 3'd3,
      KIND_DATE = 3'd4
   } kind_type;

   // Result status
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_CODE  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   // Conversion applied to the assembled bytes when the value completes
   typedef enum logic [1:0] {
      FIX_NONE    = 2'd0,
      FIX_SEXT32  = 2'd1,
      FIX_MINUTES = 2'd2
   } fix_type;

   // Single-byte type codes
   localparam logic [7:0] CODE_INT32    = 8'h49;
   localparam logic [7:0] CODE_LONG32   = 8'h59;
   localparam logic [7:0] CODE_LONG64   = 8'h4c;
   localparam logic [7:0] CODE_FALSE    = 8'h46;
   localparam logic [7:0] CODE_TRUE     = 8'h54;
   localparam logic [7:0] CODE_NULL     = 8'h4e;
   localparam logic [7:0] CODE_DATE_MIN = 8'h4b;
   localparam logic [7:0] CODE_DATE_MS  = 8'h4a;

   // Bias of the compact forms
   localparam logic [7:0] INT_ZERO_1B  = 8'h90;
   localparam logic [7:0] INT_ZERO_2B  = 8'hc8;
   localparam logic [7:0] INT_ZERO_3B  = 8'hd4;
   localparam logic [7:0] LONG_ZERO_1B = 8'he0;
   localparam logic [7:0] LONG_ZERO_2B = 8'hf8;
   localparam logic [7:0] LONG_ZERO_3B = 8'h3c;

   localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

   // One byte of the input stream
   typedef struct packed {
      logic [7:0] data_byte;
      logic [2:0] expected_kind;
      logic       buffer_end;
   } item_type;

   // Classification of a type-code byte
   typedef struct packed {
      logic        ok;
      logic [3:0]  need;
      logic [63:0] init;
      fix_type     fix;
   } code_info_type;

   // One result item
   typedef struct packed {
      logic [63:0] value;
      logic [3:0]  consumed_bytes;
      status_type  status;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/hsd_code_decode.sv]
// Classifies a type-code byte against the expected kind: legality,
// number of trailing bytes, initial accumulator and final conversion.
// Depends on hsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsd_code_decode (
   input  wire logic [7:0]            code,
   input  wire logic [2:0]            kind,
   output hsd_pkg::code_info_type     info
);
   import hsd_pkg::*;

   logic [63:0] code_ext;

   assign code_ext = 64'(code);

   // Decode the code per expected kind
   always_comb begin
      info.ok   = 1'b1;
      info.need = 4'd0;
      info.init = '0;
      info.fix  = FIX_NONE;
      case (kind)
         KIND_INT: begin
            if (code >= 8'h80 && code <= 8'hbf) begin
               info.init = code_ext - 64'(INT_ZERO_1B);
            end else if (code >= 8'hc0 && code <= 8'hcf) begin
               info.init = code_ext - 64'(INT_ZERO_2B);
               info.need = 4'd1;
            end else if (code >= 8'hd0 && code <= 8'hd7) begin
               info.init = code_ext - 64'(INT_ZERO_3B);
               info.need = 4'd2;
            end else if (code == CODE_INT32) begin
               info.need = 4'd4;
               info.fix  = FIX_SEXT32;
            end else begin
               info.ok = 1'b0;
            end
         end
         KIND_LONG: begin
            if (code >= 8'hd8 && code <= 8'hef) begin
               info.init = code_ext - 64'(LONG_ZERO_1B);
            end else if (code >= 8'hf0) begin
               info.init = code_ext - 64'(LONG_ZERO_2B);
               info.need = 4'd1;
            end else if (code >= 8'h38 && code <= 8'h3f) begin
               info.init = code_ext - 64'(LONG_ZERO_3B);
               info.need = 4'd2;
            end else if (code == CODE_LONG32) begin
               info.need = 4'd4;
               info.fix  = FIX_SEXT32;
            end else if (code == CODE_LONG64) begin
               info.need = 4'd8;
            end else begin
               info.ok = 1'b0;
            end
         end
         KIND_BOOL: begin
            if (code == CODE_TRUE) begin
               info.init = 64'd1;
            end else if (code != CODE_FALSE) begin
               info.ok = 1'b0;
            end
         end
         KIND_NULL: begin
            if (code != CODE_NULL) begin
               info.ok = 1'b0;
            end
         end
         KIND_DATE: begin
            if (code == CODE_DATE_MIN) begin
               info.need = 4'd4;
               info.fix  = FIX_MINUTES;
            end else if (code == CODE_DATE_MS) begin
               info.need = 4'd8;
            end else begin
               info.ok = 1'b0;
            end
         end
         default: begin
            info.ok = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/hsd_assemble.sv]
// Decoder state and byte assembly: holds the remaining byte count, the
// accumulator and the byte count, and forms one result per finished value.
// Depends on hsd_pkg and hsd_code_decode.
`timescale 1ns / 1ps
`default_nettype none

module hsd_assemble (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire hsd_pkg::item_type     item,
   output logic                       res_valid,
   output hsd_pkg::result_type        result
);
   import hsd_pkg::*;

   logic [3:0]    bytes_left_ff, bytes_left_in;
   logic [63:0]   acc_ff, acc_in;
   logic [3:0]    count_ff, count_in;
   fix_type       fix_ff, fix_in;

   code_info_type info;
   logic          idle;
   logic [63:0]   acc_shift;
   logic [3:0]    count_inc;
   logic [3:0]    left_dec;
   logic [47:0]   minutes_ms;
   logic [63:0]   final_value;

   hsd_code_decode u_code_decode (
      .code (item.data_byte),
      .kind (item.expected_kind),
      .info (info)
   );

   assign idle      = (bytes_left_ff == 4'd0);
   assign acc_shift = {acc_ff[55:0], item.data_byte};
   assign count_inc = count_ff + 4'd1;
   assign left_dec  = bytes_left_ff - 4'd1;
   assign minutes_ms = {16'd0, acc_shift[31:0]} * {32'd0, MS_PER_MINUTE};

   // Apply the final conversion of the completed value
   always_comb begin
      case (fix_ff)
         FIX_SEXT32:  final_value = {{32{acc_shift[31]}}, acc_shift[31:0]};
         FIX_MINUTES: final_value = 64'(minutes_ms);
         default:     final_value = acc_shift;
      endcase
   end

   // Next state and result for the byte at hand
   always_comb begin
      bytes_left_in         = bytes_left_ff;
      acc_in                = acc_ff;
      count_in              = count_ff;
      fix_in                = fix_ff;
      res_valid             = 1'b0;
      result.value          = '0;
      result.consumed_bytes = 4'd1;
      result.status         = STATUS_OK;
      if (idle) begin
         acc_in   = info.init;
         count_in = 4'd1;
         fix_in   = info.fix;
         if (!info.ok) begin
            res_valid     = 1'b1;
            result.status = STATUS_BAD_CODE;
         end else if (info.need == 4'd0) begin
            res_valid    = 1'b1;
            result.value = info.init;
         end else if (item.buffer_end) begin
            res_valid     = 1'b1;
            result.status = STATUS_UNDERFLOW;
         end else begin
            bytes_left_in = info.need;
         end
      end else begin
         acc_in                = acc_shift;
         count_in              = count_inc;
         result.consumed_bytes = count_inc;
         if (left_dec == 4'd0) begin
            bytes_left_in = 4'd0;
            res_valid     = 1'b1;
            result.value  = final_value;
         end else if (item.buffer_end) begin
            bytes_left_in = 4'd0;
            res_valid     = 1'b1;
            result.status = STATUS_UNDERFLOW;
         end else begin
            bytes_left_in = left_dec;
         end
      end
   end

   // Advance state on each processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 4'd0;
      end else if (advance) begin
         bytes_left_ff <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
         fix_ff   <= fix_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/hessian_scalar_decoder.sv]
// Hessian 2 scalar decoder: byte stream in, decoded int/long/bool/null/date
// values out. Depends on hsd_pkg, hsd_assemble and hsd_code_decode.
//
// Usage:
//   Input channel (req_): one stream byte per transfer. On the first byte of
//   a value (the type code) req_expected_kind selects int, long, bool, null
//   or date; it is ignored on the bytes that follow. req_buffer_end marks
//   the last byte available; if a value is still incomplete on that byte the
//   decoder reports an underflow and returns to waiting for a type code.
//   Result channel (rsp_): one transfer per finished value, wrong code or
//   underflow, carrying the signed value, the bytes consumed including the
//   type code, and the status.
//   Throughput: one byte per cycle while no byte waits on a held result.
//   Each byte is held in the input register and is then folded into the
//   accumulator; the result register is loaded on that same edge, so a
//   result passes the input register and then the result register.
//   Stall: while rsp_valid is held without rsp_ready, bytes that end no
//   value keep flowing; a byte that would produce a second result waits in
//   the input register and req_ready drops until the result is taken.
//   Reset: synchronous; both registers empty and the decoder waits for a
//   type code.
`timescale 1ns / 1ps
`default_nettype none

module hessian_scalar_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic [2:0]         req_expected_kind,
   input  wire logic               req_buffer_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [63:0]      rsp_value,
   output logic [3:0]              rsp_consumed_bytes,
   output logic [1:0]              rsp_status
);
   import hsd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   logic       res_valid;
   result_type result;
   logic       advance;
   logic       load;

   hsd_assemble u_assemble (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (in_item_ff),
      .res_valid (res_valid),
      .result    (result)
   );

   // Process the held byte unless its result has nowhere to go
   assign advance   = in_valid_ff && (!res_valid || !rsp_valid_ff || rsp_ready);
   assign load      = advance && res_valid;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture input and result payloads
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_item_ff.data_byte     <= req_data_byte;
         in_item_ff.expected_kind <= req_expected_kind;
         in_item_ff.buffer_end    <= req_buffer_end;
      end
      if (load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = signed'(rsp_ff.value);
   assign rsp_consumed_bytes = rsp_ff.consumed_bytes;
   assign rsp_status         = rsp_ff.status;

`ifndef SYNTH
   a_bad_code_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_CODE |->
         rsp_consumed_bytes == 4'd1 && rsp_value == 64'sd0)
      else $error("wrong-code result with value or length");

   a_underflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_UNDERFLOW |-> rsp_value == 64'sd0)
      else $error("underflow result with nonzero value");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_consumed_bytes != 4'd0 && rsp_consumed_bytes <= 4'd9)
      else $error("consumed byte count out of range");

   a_stall_holds_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled input byte lost or changed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire
